// ===== rtl/core/cdq_pkg.sv =====
package cdq_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    ACT_INS_REAR  = 2'd0,
    ACT_INS_FRONT = 2'd1,
    ACT_DEL_FRONT = 2'd2,
    ACT_DEL_REAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic             en;
    logic [WordW-1:0] data;
  } wr_req_t;

endpackage

// ===== rtl/core/cdq_store.sv =====
module cdq_store
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned PW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  wr_req_t          wr_i,
  input  logic [PW-1:0]    wr_addr_i,
  input  logic [PW-1:0]    rd_a_addr_i,
  input  logic [PW-1:0]    rd_b_addr_i,
  output logic [WordW-1:0] rd_a_data_o,
  output logic [WordW-1:0] rd_b_data_o
);

  logic [WordW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_data_o <= mem[rd_a_addr_i];
    rd_b_data_o <= mem[rd_b_addr_i];
  end

endmodule

// ===== rtl/core/circular_double_ended_queue_top.sv =====
// each word is accepted and written, then read at the new head and tail through the
// store's registered read port, then captured into the output register; no new word
// is taken (in_stall_o high) until the capture step returns the sequencer to idle
// a stalled output holds the capture step until the result register frees up
// reset: asynchronous active low, deque empty, head and tail at zero, no result pending
module circular_double_ended_queue_top
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic               is_empty_o,
  output logic               is_full_o,
  output logic [4:0]         occupancy_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] rear_value_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPos = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CAP  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    stat_q, stat_d;
  logic          out_valid_q, out_valid_d;

  logic [1:0]       status_q;
  logic             is_empty_q;
  logic             is_full_q;
  logic [4:0]       occupancy_q;
  logic [WordW-1:0] front_q;
  logic [WordW-1:0] rear_q;

  wr_req_t          wr;
  logic [PW-1:0]    wr_addr;
  logic [WordW-1:0] rd_a_data;
  logic [WordW-1:0] rd_b_data;
  logic             in_acc;
  logic             cap;
  logic             is_empty;
  logic             is_full;
  logic [CW+4:0]    occ_ext;
  action_e          act;

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    return (p == LastPos) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] prev_pos(input logic [PW-1:0] p);
    return (p == '0) ? LastPos : p - 1'b1;
  endfunction

  assign act      = action_e'(action_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == FullCnt);
  assign occ_ext  = {5'b0, cnt_q};
  assign cap      = (state_q == S_CAP) && (!out_valid_q || !out_stall_i);

  cdq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .wr_addr_i  (wr_addr),
    .rd_a_addr_i(head_q),
    .rd_b_addr_i(tail_q),
    .rd_a_data_o(rd_a_data),
    .rd_b_data_o(rd_b_data)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    wr.en       = 1'b0;
    wr.data     = value_i;
    wr_addr     = '0;
    in_stall_o  = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RD;
          stat_d  = ST_DONE;
          if (act == ACT_INS_REAR || act == ACT_INS_FRONT) begin
            if (is_full) begin
              stat_d = ST_FULL;
            end else if (is_empty) begin
              head_d  = '0;
              tail_d  = '0;
              wr.en   = 1'b1;
              wr_addr = '0;
              cnt_d   = cnt_q + 1'b1;
            end else if (act == ACT_INS_REAR) begin
              tail_d  = next_pos(tail_q);
              wr.en   = 1'b1;
              wr_addr = next_pos(tail_q);
              cnt_d   = cnt_q + 1'b1;
            end else begin
              head_d  = prev_pos(head_q);
              wr.en   = 1'b1;
              wr_addr = prev_pos(head_q);
              cnt_d   = cnt_q + 1'b1;
            end
          end else begin
            if (is_empty) begin
              stat_d = ST_EMPTY;
            end else if (cnt_q == CW'(1)) begin
              head_d = '0;
              tail_d = '0;
              cnt_d  = '0;
            end else if (act == ACT_DEL_FRONT) begin
              head_d = next_pos(head_q);
              cnt_d  = cnt_q - 1'b1;
            end else begin
              tail_d = prev_pos(tail_q);
              cnt_d  = cnt_q - 1'b1;
            end
          end
        end
      end
      S_RD: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        if (cap) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cap) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      stat_q      <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      status_q    <= stat_q;
      is_empty_q  <= is_empty;
      is_full_q   <= is_full;
      occupancy_q <= occ_ext[4:0];
      front_q     <= is_empty ? '0 : rd_a_data;
      rear_q      <= is_empty ? '0 : rd_b_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign is_empty_o    = is_empty_q;
  assign is_full_o     = is_full_q;
  assign occupancy_o   = occupancy_q;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("occupancy above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("pointers not parked while empty");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (cnt_q == ((tail_q >= head_q) ?
      CW'(tail_q - head_q) + CW'(1) :
      CW'(DEPTH) - CW'(head_q - tail_q) + CW'(1))))
    else $error("occupancy disagrees with pointers");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RD) ##1 (state_q == S_CAP))
    else $error("sequencer skipped a step");

  a_cap_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap |=> out_valid_q)
    else $error("captured result not presented");
`endif

endmodule

// ===== verif/circular_double_ended_queue_checker.sv =====
`timescale 1ns / 100ps
module circular_double_ended_queue_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic               is_empty_i,
  input  logic               is_full_i,
  input  logic [4:0]         occupancy_i,
  input  logic signed [31:0] front_value_i,
  input  logic signed [31:0] rear_value_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        done_count_o,
  output int unsigned        full_reject_count_o,
  output int unsigned        empty_reject_count_o
);

  typedef struct packed {
    status_e          status;
    logic             empty;
    logic             full;
    logic [4:0]       occupancy;
    logic [WordW-1:0] front;
    logic [WordW-1:0] rear;
  } deque_view_t;

  logic [WordW-1:0] slot_q [DEPTH];
  int unsigned      head_q;
  int unsigned      tail_q;
  int unsigned      held_q;
  deque_view_t      expected_views [$];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %h, want %h", $time, field, got, want);
    fail_count_o++;
  endtask

  function automatic deque_view_t apply_action(action_e act, logic [WordW-1:0] word);
    deque_view_t view;
    view.status = ST_DONE;
    if (act == ACT_INS_REAR || act == ACT_INS_FRONT) begin
      if (held_q == DEPTH) begin
        view.status = ST_FULL;
      end else begin
        if (held_q == 0) begin
          head_q    = 0;
          tail_q    = 0;
          slot_q[0] = word;
        end else if (act == ACT_INS_REAR) begin
          tail_q         = (tail_q + 1) % DEPTH;
          slot_q[tail_q] = word;
        end else begin
          head_q         = (head_q + DEPTH - 1) % DEPTH;
          slot_q[head_q] = word;
        end
        held_q++;
      end
    end else if (held_q == 0) begin
      view.status = ST_EMPTY;
    end else begin
      held_q--;
      if (held_q == 0) begin
        head_q = 0;
        tail_q = 0;
      end else if (act == ACT_DEL_FRONT) begin
        head_q = (head_q + 1) % DEPTH;
      end else begin
        tail_q = (tail_q + DEPTH - 1) % DEPTH;
      end
    end
    view.empty     = (held_q == 0);
    view.full      = (held_q == DEPTH);
    view.occupancy = 5'(held_q);
    view.front     = (held_q == 0) ? '0 : slot_q[head_q];
    view.rear      = (held_q == 0) ? '0 : slot_q[tail_q];
    return view;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_view_t want;
    if (!rst_ni) begin
      head_q               = 0;
      tail_q               = 0;
      held_q               = 0;
      expected_views.delete();
      fail_count_o         = 0;
      done_count_o         = 0;
      full_reject_count_o  = 0;
      empty_reject_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_views.push_back(apply_action(action_e'(action_i), value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          report_mismatch("word with nothing pending", {30'd0, status_i}, '0);
        end else begin
          want = expected_views.pop_front();
          if (status_i !== want.status) begin
            report_mismatch("status", {30'd0, status_i}, {30'd0, want.status});
          end
          if (is_empty_i !== want.empty) begin
            report_mismatch("is_empty", {31'd0, is_empty_i}, {31'd0, want.empty});
          end
          if (is_full_i !== want.full) begin
            report_mismatch("is_full", {31'd0, is_full_i}, {31'd0, want.full});
          end
          if (occupancy_i !== want.occupancy) begin
            report_mismatch("occupancy", {27'd0, occupancy_i}, {27'd0, want.occupancy});
          end
          if (front_value_i !== want.front) begin
            report_mismatch("front_value", front_value_i, want.front);
          end
          if (rear_value_i !== want.rear) begin
            report_mismatch("rear_value", rear_value_i, want.rear);
          end
          case (want.status)
            ST_FULL:  full_reject_count_o++;
            ST_EMPTY: empty_reject_count_o++;
            default:  done_count_o++;
          endcase
        end
      end
    end
    pending_o = expected_views.size();
  end

endmodule

// ===== verif/circular_double_ended_queue_top_test.sv =====
`timescale 1ns / 100ps
module circular_double_ended_queue_top_test;
  import cdq_pkg::*;

  localparam int unsigned Depth       = 16;
  localparam int unsigned RandomWords = 1900;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned HoldEvery   = 3000;
  localparam int unsigned HoldCycles  = 150;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [1:0]         action     = ACT_INS_REAR;
  logic signed [31:0] value      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [1:0]         status;
  logic               is_empty;
  logic               is_full;
  logic [4:0]         occupancy;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned done_count;
  int unsigned full_reject_count;
  int unsigned empty_reject_count;
  int unsigned sent_count  = 0;
  int unsigned long_holds  = 0;
  int unsigned cycle_count = 0;

  circular_double_ended_queue_top #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .is_empty_o   (is_empty),
    .is_full_o    (is_full),
    .occupancy_o  (occupancy),
    .front_value_o(front_value),
    .rear_value_o (rear_value)
  );

  circular_double_ended_queue_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .action_i            (action),
    .value_i             (value),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .status_i            (status),
    .is_empty_i          (is_empty),
    .is_full_i           (is_full),
    .occupancy_i         (occupancy),
    .front_value_i       (front_value),
    .rear_value_i        (rear_value),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .done_count_o        (done_count),
    .full_reject_count_o (full_reject_count),
    .empty_reject_count_o(empty_reject_count)
  );

  always #5 clk = ~clk;

  // stall is sampled at the falling edge, where it is settled for the coming rising edge
  task automatic send_word(input action_e act, input logic [31:0] word);
    in_valid <= 1'b1;
    action   <= act;
    value    <= word;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sent_count++;
  endtask

  task automatic idle_sender();
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mode 0 leans to inserts, mode 1 to deletes, mode 2 is even
  function automatic action_e pick_action(input int unsigned mode);
    int unsigned r;
    logic        do_insert;
    r         = $urandom_range(0, 99);
    do_insert = (mode == 0) ? (r < 85) : (mode == 1) ? (r < 15) : (r < 50);
    if (do_insert) begin
      return $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_REAR;
    end
    return $urandom_range(0, 1) ? ACT_DEL_REAR : ACT_DEL_FRONT;
  endfunction

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned ticks;
    logic        stall_now;
    ticks = 0;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (ticks >= HoldEvery) begin
        len       = HoldCycles;
        stall_now = 1'b1;
        ticks     = 0;
        long_holds++;
      end else if (r < 55) begin
        len       = $urandom_range(1, 25);
        stall_now = 1'b0;
      end else if (r < 92) begin
        len       = $urandom_range(1, 3);
        stall_now = 1'b1;
      end else begin
        len       = $urandom_range(8, 30);
        stall_now = 1'b1;
      end
      out_stall <= stall_now;
      repeat (len) @(posedge clk);
      ticks += len;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned seg_left;
    seg_left = 0;
    mode     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // deletes on empty, single-entry deletes from both ends, then fill to full and insert at both ends while full
    send_word(ACT_DEL_FRONT, 32'h1234_5678);
    idle_sender();
    send_word(ACT_DEL_REAR, 32'hffff_ffff);
    idle_sender();
    send_word(ACT_INS_REAR, 32'h7fff_ffff);
    idle_sender();
    send_word(ACT_DEL_REAR, 32'h0000_0000);
    idle_sender();
    send_word(ACT_INS_FRONT, 32'h8000_0000);
    idle_sender();
    send_word(ACT_DEL_FRONT, 32'h0000_0000);
    idle_sender();
    send_word(ACT_INS_FRONT, 32'h0000_0000);
    idle_sender();
    for (int i = 0; i < Depth - 1; i++) begin
      send_word((i % 2) ? ACT_INS_FRONT : ACT_INS_REAR, pick_word());
      idle_sender();
    end
    send_word(ACT_INS_REAR, 32'haaaa_5555);
    idle_sender();
    send_word(ACT_INS_FRONT, 32'h5555_aaaa);
    idle_sender();

    for (int n = 0; n < RandomWords; n++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 50);
      end
      send_word(pick_action(mode), pick_word());
      seg_left--;
      idle_sender();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d operations: %0d completed, %0d refused as full, %0d refused as empty",
             sent_count, done_count, full_reject_count, empty_reject_count);
    $display("output held off for %0d long stretches", long_holds);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
